// ===== design/ttl_pkg.sv =====
package ttl_pkg;

    // Token classes carried on every result beat.
    localparam logic [2:0] CLS_NUMBER = 3'd0;
    localparam logic [2:0] CLS_STRING = 3'd1;
    localparam logic [2:0] CLS_DELIM  = 3'd2;
    localparam logic [2:0] CLS_SYMBOL = 3'd3;
    localparam logic [2:0] CLS_END    = 3'd4;

    // Error codes, given on the last beat of a token only.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NL_IN_STR  = 2'd1;
    localparam logic [1:0] ERR_EOT_IN_STR = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG   = 2'd3;

    // Configuration register indexes.
    localparam logic REG_DELIM_LOW  = 1'b0;
    localparam logic REG_DELIM_HIGH = 1'b1;

    // Character codes the lexer treats specially.
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE_MAX = 8'd32;
    localparam logic [7:0] CH_QUOTE     = 8'd34;
    localparam logic [7:0] CH_STAR      = 8'd42;
    localparam logic [7:0] CH_PLUS      = 8'd43;
    localparam logic [7:0] CH_MINUS     = 8'd45;
    localparam logic [7:0] CH_SLASH     = 8'd47;
    localparam logic [7:0] CH_DIGIT_0   = 8'd48;
    localparam logic [7:0] CH_DIGIT_9   = 8'd57;

    // One input byte together with its classification.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
        logic       is_space;
        logic       is_newline;
        logic       is_delim;
        logic       is_numeric;
        logic       is_num_start;
        logic       is_quote;
        logic       is_slash;
        logic       is_star;
        logic       slash_is_delim;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic [7:0]  char_value;
        logic        has_char;
        logic [2:0]  token_class;
        logic        first_of_token;
        logic        last_of_token;
        logic [15:0] line_number;
        logic [1:0]  error_code;
        logic        last_result;
    } t_result;

endpackage

// ===== design/ttl_front.sv =====
module ttl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_index,
    input  logic [63:0]       i_cfg_wr_data,
    input  logic [7:0]        i_text_byte,
    input  logic              i_end_of_text,
    output ttl_pkg::t_item    o_item
);

    logic [63:0] r_delim_low;
    logic [63:0] r_delim_high;
    logic        delim_hit;
    logic        numeric_hit;

    // Delimiter set registers, written through the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_low  <= '0;
            r_delim_high <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == ttl_pkg::REG_DELIM_LOW) begin
                r_delim_low <= i_cfg_wr_data;
            end else begin
                r_delim_high <= i_cfg_wr_data;
            end
        end
    end

    // Codes 128 and up are never delimiters.
    always_comb begin
        if (i_text_byte[7]) begin
            delim_hit = 1'b0;
        end else if (i_text_byte[6]) begin
            delim_hit = r_delim_high[i_text_byte[5:0]];
        end else begin
            delim_hit = r_delim_low[i_text_byte[5:0]];
        end
    end

    // Characters that may continue a number.
    always_comb begin
        unique case (i_text_byte)
            "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
            "-", "+", "E", "e", ".", "#", "Q", "N", "A", "B", "I", "F": begin
                numeric_hit = 1'b1;
            end
            default: begin
                numeric_hit = 1'b0;
            end
        endcase
    end

    // Classification of the incoming byte.
    always_comb begin
        o_item.text_byte      = i_text_byte;
        o_item.end_of_text    = i_end_of_text;
        o_item.is_space       = (i_text_byte <= ttl_pkg::CH_SPACE_MAX) || i_text_byte[7];
        o_item.is_newline     = (i_text_byte == ttl_pkg::CH_NEWLINE);
        o_item.is_delim       = delim_hit;
        o_item.is_numeric     = numeric_hit;
        o_item.is_num_start   = ((i_text_byte >= ttl_pkg::CH_DIGIT_0) &&
                                 (i_text_byte <= ttl_pkg::CH_DIGIT_9)) ||
                                (i_text_byte == ttl_pkg::CH_PLUS) ||
                                (i_text_byte == ttl_pkg::CH_MINUS);
        o_item.is_quote       = (i_text_byte == ttl_pkg::CH_QUOTE);
        o_item.is_slash       = (i_text_byte == ttl_pkg::CH_SLASH);
        o_item.is_star        = (i_text_byte == ttl_pkg::CH_STAR);
        o_item.slash_is_delim = r_delim_low[ttl_pkg::CH_SLASH[5:0]];
    end

endmodule

// ===== design/ttl_item_fifo.sv =====
module ttl_item_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ttl_pkg::t_item    i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output ttl_pkg::t_item    o_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ttl_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_fire;
    logic             rd_fire;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign wr_fire = i_push && !o_full;
    assign rd_fire = i_pop && o_valid;

    // Storage for classified bytes.
    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_fire) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (rd_fire) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (wr_fire && !rd_fire) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!wr_fire && rd_fire) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== design/ttl_back.sv =====
module ttl_back #(
    parameter int MAX_TOKEN_CHARS = 255
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  ttl_pkg::t_item             i_item,
    output logic [1:0]                 o_res_cnt,
    output ttl_pkg::t_result [1:0]     o_res
);

    localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_LINEC  = 3'd1;
    localparam logic [2:0] MODE_BLOCKC = 3'd2;
    localparam logic [2:0] MODE_NUM    = 3'd3;
    localparam logic [2:0] MODE_STR    = 3'd4;
    localparam logic [2:0] MODE_SYM    = 3'd5;

    logic [2:0]       r_mode,     n_mode;
    logic             r_ovf,      n_ovf;
    logic             r_slash,    n_slash;
    logic [7:0]       r_held,     n_held;
    logic             r_hv,       n_hv;
    logic [LEN_W-1:0] r_len,      n_len;
    logic [15:0]      r_line,     n_line;
    logic [15:0]      r_tok_line, n_tok_line;
    logic             r_star,     n_star;

    ttl_pkg::t_result [1:0] e_res;
    logic [1:0]             e_cnt;
    logic                   do_end;
    logic [1:0]             end_err;
    logic                   do_accept;
    logic                   do_idle;
    logic [7:0]             c;

    function automatic logic [2:0] class_of_mode(input logic [2:0] mode);
        if (mode == MODE_NUM) begin
            return ttl_pkg::CLS_NUMBER;
        end else if (mode == MODE_STR) begin
            return ttl_pkg::CLS_STRING;
        end
        return ttl_pkg::CLS_SYMBOL;
    endfunction

    function automatic ttl_pkg::t_result make_res(
        input logic [7:0]  ch,
        input logic        has,
        input logic [2:0]  cls,
        input logic        first,
        input logic        last,
        input logic [15:0] line,
        input logic [1:0]  err
    );
        ttl_pkg::t_result r;
        r.char_value     = ch;
        r.has_char       = has;
        r.token_class    = cls;
        r.first_of_token = first;
        r.last_of_token  = last;
        r.line_number    = line;
        r.error_code     = err;
        r.last_result    = 1'b0;
        return r;
    endfunction

    function automatic logic [15:0] bump(input logic [15:0] line);
        return (line == 16'hFFFF) ? line : line + 16'd1;
    endfunction

    assign c         = i_item.text_byte;
    assign o_res_cnt = e_cnt;
    assign o_res     = e_res;

    // One lexer step: up to two result beats per byte.
    always_comb begin
        n_mode     = r_mode;
        n_ovf      = r_ovf;
        n_slash    = r_slash;
        n_held     = r_held;
        n_hv       = r_hv;
        n_len      = r_len;
        n_line     = r_line;
        n_tok_line = r_tok_line;
        n_star     = r_star;
        e_res      = '0;
        e_cnt      = 2'd0;
        do_end     = 1'b0;
        end_err    = ttl_pkg::ERR_NONE;
        do_accept  = 1'b0;
        do_idle    = 1'b0;

        // Dispatch on the current mode; the shared actions follow below.
        if (i_item.end_of_text) begin
            if (r_slash) begin
                e_res[e_cnt[0]] = make_res(ttl_pkg::CH_SLASH, 1'b1,
                    i_item.slash_is_delim ? ttl_pkg::CLS_DELIM : ttl_pkg::CLS_SYMBOL,
                    1'b1, 1'b1, r_tok_line, ttl_pkg::ERR_NONE);
                e_cnt = e_cnt + 2'd1;
            end else if (r_mode == MODE_NUM || r_mode == MODE_SYM) begin
                do_end = 1'b1;
            end else if (r_mode == MODE_STR) begin
                do_end  = 1'b1;
                end_err = ttl_pkg::ERR_EOT_IN_STR;
            end
        end else if (r_slash) begin
            n_slash = 1'b0;
            if (i_item.is_slash) begin
                n_mode = MODE_LINEC;
            end else if (i_item.is_star) begin
                n_mode = MODE_BLOCKC;
                n_star = 1'b0;
            end else if (i_item.slash_is_delim) begin
                e_res[e_cnt[0]] = make_res(ttl_pkg::CH_SLASH, 1'b1, ttl_pkg::CLS_DELIM,
                    1'b1, 1'b1, r_tok_line, ttl_pkg::ERR_NONE);
                e_cnt   = e_cnt + 2'd1;
                do_idle = 1'b1;
            end else begin
                n_mode = MODE_SYM;
                n_ovf  = 1'b0;
                n_held = ttl_pkg::CH_SLASH;
                n_hv   = 1'b1;
                n_len  = LEN_W'(1);
                if (i_item.is_space || i_item.is_delim) begin
                    do_end  = 1'b1;
                    do_idle = 1'b1;
                end else begin
                    do_accept = 1'b1;
                end
            end
        end else begin
            unique case (r_mode)
                MODE_LINEC: begin
                    if (i_item.is_newline) begin
                        n_line = bump(r_line);
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_BLOCKC: begin
                    if (i_item.is_newline) begin
                        n_line = bump(r_line);
                    end
                    if (r_star && i_item.is_slash) begin
                        n_mode = MODE_IDLE;
                        n_star = 1'b0;
                    end else begin
                        n_star = i_item.is_star;
                    end
                end
                MODE_NUM: begin
                    if (i_item.is_numeric) begin
                        do_accept = 1'b1;
                    end else begin
                        do_end  = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                MODE_STR: begin
                    if (i_item.is_quote) begin
                        do_end = 1'b1;
                    end else if (i_item.is_newline) begin
                        do_end  = 1'b1;
                        end_err = ttl_pkg::ERR_NL_IN_STR;
                        n_line  = bump(r_line);
                    end else begin
                        do_accept = 1'b1;
                    end
                end
                MODE_SYM: begin
                    if (i_item.is_space || i_item.is_delim) begin
                        do_end  = 1'b1;
                        do_idle = 1'b1;
                    end else begin
                        do_accept = 1'b1;
                    end
                end
                default: begin
                    n_mode  = MODE_IDLE;
                    n_ovf   = 1'b0;
                    do_idle = 1'b1;
                end
            endcase
        end

        // Close the open token with its held character, if one is held.
        if (do_end) begin
            if (end_err == ttl_pkg::ERR_NONE && n_ovf) begin
                end_err = ttl_pkg::ERR_TOO_LONG;
            end
            if (n_hv) begin
                e_res[e_cnt[0]] = make_res(n_held, 1'b1, class_of_mode(n_mode),
                    n_len == LEN_W'(1), 1'b1, n_tok_line, end_err);
            end else begin
                e_res[e_cnt[0]] = make_res(8'd0, 1'b0, class_of_mode(n_mode),
                    1'b1, 1'b1, n_tok_line, end_err);
            end
            e_cnt  = e_cnt + 2'd1;
            n_mode = MODE_IDLE;
            n_ovf  = 1'b0;
            n_hv   = 1'b0;
            n_held = 8'd0;
            n_len  = '0;
        end

        // Take a character into the token; the previous one leaves now, and past the limit the new one is dropped.
        if (do_accept) begin
            if (n_len < LEN_W'(MAX_TOKEN_CHARS)) begin
                if (n_hv) begin
                    e_res[e_cnt[0]] = make_res(n_held, 1'b1, class_of_mode(n_mode),
                        n_len == LEN_W'(1), 1'b0, n_tok_line, ttl_pkg::ERR_NONE);
                    e_cnt = e_cnt + 2'd1;
                end
                n_held = c;
                n_hv   = 1'b1;
                n_len  = n_len + LEN_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end

        // Handle a byte seen between tokens.
        if (do_idle) begin
            priority if (i_item.is_space) begin
                if (i_item.is_newline) begin
                    n_line = bump(n_line);
                end
            end else if (i_item.is_slash) begin
                n_slash    = 1'b1;
                n_tok_line = n_line;
            end else if (i_item.is_num_start) begin
                n_mode     = MODE_NUM;
                n_ovf      = 1'b0;
                n_tok_line = n_line;
                n_hv       = 1'b1;
                n_held     = c;
                n_len      = LEN_W'(1);
            end else if (i_item.is_quote) begin
                n_mode     = MODE_STR;
                n_ovf      = 1'b0;
                n_tok_line = n_line;
                n_hv       = 1'b0;
                n_held     = 8'd0;
                n_len      = '0;
            end else if (i_item.is_delim) begin
                e_res[e_cnt[0]] = make_res(c, 1'b1, ttl_pkg::CLS_DELIM,
                    1'b1, 1'b1, n_line, ttl_pkg::ERR_NONE);
                e_cnt = e_cnt + 2'd1;
            end else begin
                n_mode     = MODE_SYM;
                n_ovf      = 1'b0;
                n_tok_line = n_line;
                n_hv       = 1'b1;
                n_held     = c;
                n_len      = LEN_W'(1);
            end
        end

        // End of text: end token, then back to the reset state.
        if (i_item.end_of_text) begin
            e_res[e_cnt[0]] = make_res(8'd0, 1'b0, ttl_pkg::CLS_END,
                1'b1, 1'b1, r_line, ttl_pkg::ERR_NONE);
            e_cnt      = e_cnt + 2'd1;
            n_mode     = MODE_IDLE;
            n_ovf      = 1'b0;
            n_slash    = 1'b0;
            n_held     = 8'd0;
            n_hv       = 1'b0;
            n_len      = '0;
            n_line     = 16'd1;
            n_tok_line = 16'd1;
            n_star     = 1'b0;
        end

        // Mark the final beat caused by this byte.
        if (e_cnt == 2'd2) begin
            e_res[1].last_result = 1'b1;
        end else if (e_cnt == 2'd1) begin
            e_res[0].last_result = 1'b1;
        end

        if (!i_fire) begin
            e_cnt = 2'd0;
        end
    end

    // Lexer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_ovf      <= 1'b0;
            r_slash    <= 1'b0;
            r_held     <= 8'd0;
            r_hv       <= 1'b0;
            r_len      <= '0;
            r_line     <= 16'd1;
            r_tok_line <= 16'd1;
            r_star     <= 1'b0;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_ovf      <= n_ovf;
            r_slash    <= n_slash;
            r_held     <= n_held;
            r_hv       <= n_hv;
            r_len      <= n_len;
            r_line     <= n_line;
            r_tok_line <= n_tok_line;
            r_star     <= n_star;
        end
    end

endmodule

// ===== design/ttl_res_fifo.sv =====
module ttl_res_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_wr_cnt,
    input  ttl_pkg::t_result [1:0]     i_wr_data,
    output logic                       o_room,
    input  logic                       i_pop,
    output logic                       o_empty,
    output ttl_pkg::t_result           o_rd_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ttl_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             rd_fire;

    assign o_empty   = (r_count == '0);
    assign o_room    = (r_count <= CNT_W'(DEPTH - 2));
    assign o_rd_data = r_mem[r_rd_ptr];
    assign rd_fire   = i_pop && !o_empty;

    // Up to two result beats are written per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_wr_data[0];
        end
        if (i_wr_cnt == 2'd2) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_wr_data[1];
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_wr_cnt);
            if (rd_fire) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_wr_cnt) - CNT_W'(rd_fire);
        end
    end

endmodule

// ===== design/text_token_lexer.sv =====
// Streaming lexer: one text byte per push beat, with end_of_text closing the text.
// Whitespace, // and block comments are skipped, and every token character up to the
// length limit leaves as one result beat with its class, first/last marks and the
// line where the token began; the last character of a token leaves one byte late,
// once its end is known. A byte is taken every cycle while full is low. A byte
// causes up to two result beats; the result queue hands out one beat per cycle
// while pop is high, so a text that causes two beats per byte runs at the pop
// rate. A byte enters a four-entry queue, and the lexer step takes it once the
// four-entry result queue has room for two beats. The user must write delimiter
// sets only while no text is in flight; the block does not enforce it.
module text_token_lexer #(
    parameter int MAX_TOKEN_CHARS = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_char_value,
    output logic        o_has_char,
    output logic [2:0]  o_token_class,
    output logic        o_first_of_token,
    output logic        o_last_of_token,
    output logic [15:0] o_line_number,
    output logic [1:0]  o_error_code,
    output logic        o_last_result
);

    ttl_pkg::t_item         in_item;
    ttl_pkg::t_item         q_item;
    logic                   q_valid;
    logic                   res_room;
    logic                   step_fire;
    logic [1:0]             res_cnt;
    ttl_pkg::t_result [1:0] res_beats;
    ttl_pkg::t_result       out_beat;

    // Classification and configuration registers.
    ttl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_item        (in_item)
    );

    // Queue between the front and the lexer step.
    ttl_item_fifo u_item_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .o_full  (full),
        .i_pop   (step_fire),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    assign step_fire = q_valid && res_room;

    // Lexer state machine.
    ttl_back #(
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (step_fire),
        .i_item    (q_item),
        .o_res_cnt (res_cnt),
        .o_res     (res_beats)
    );

    // Result queue toward the consumer.
    ttl_res_fifo u_res_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_cnt  (res_cnt),
        .i_wr_data (res_beats),
        .o_room    (res_room),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_rd_data (out_beat)
    );

    assign o_char_value     = out_beat.char_value;
    assign o_has_char       = out_beat.has_char;
    assign o_token_class    = out_beat.token_class;
    assign o_first_of_token = out_beat.first_of_token;
    assign o_last_of_token  = out_beat.last_of_token;
    assign o_line_number    = out_beat.line_number;
    assign o_error_code     = out_beat.error_code;
    assign o_last_result    = out_beat.last_result;

endmodule

// ===== verif/text_token_lexer_test.sv =====
`timescale 1ns / 100ps

// Characters that continue a number once it has started.
localparam string NUMBER_CHARS = "0123456789-+Ee.#QNABIF";

// Tracks the lexer state for every accepted byte and keeps the result beats it must produce.
class token_scoreboard;
    typedef enum logic [2:0] {
        LX_IDLE      = 3'd0,
        LX_LINE_CMT  = 3'd1,
        LX_BLOCK_CMT = 3'd2,
        LX_NUMBER    = 3'd3,
        LX_STRING    = 3'd4,
        LX_SYMBOL    = 3'd5
    } t_lex_mode;

    localparam int MAX_TOKEN_CHARS = 255;

    logic [63:0]      delim_low;
    logic [63:0]      delim_high;
    t_lex_mode        mode;
    bit               overflow;
    bit               slash_wait;
    bit               star_seen;
    bit               held_valid;
    logic [7:0]       held_char;
    int unsigned      token_len;
    logic [15:0]      line_count;
    logic [15:0]      token_line;
    ttl_pkg::t_result expected_beats[$];
    int               errors;
    int               beats_checked;

    function new();
        delim_low = '0;
        delim_high = '0;
        errors = 0;
        beats_checked = 0;
        clear_state();
    endfunction

    function void clear_state();
        mode = LX_IDLE;
        overflow = 1'b0;
        slash_wait = 1'b0;
        star_seen = 1'b0;
        held_valid = 1'b0;
        held_char = 8'd0;
        token_len = 0;
        line_count = 16'd1;
        token_line = 16'd1;
    endfunction

    function void set_delims(logic [127:0] mask);
        delim_low = mask[63:0];
        delim_high = mask[127:64];
    endfunction

    function int beats_waiting();
        return expected_beats.size();
    endfunction

    function bit is_space(logic [7:0] c);
        return (c <= ttl_pkg::CH_SPACE_MAX) || c[7];
    endfunction

    function bit is_delim(logic [7:0] c);
        if (c[7]) return 1'b0;
        return c[6] ? delim_high[c[5:0]] : delim_low[c[5:0]];
    endfunction

    function bit is_numeric(logic [7:0] c);
        logic [7:0] n;
        for (int i = 0; i < NUMBER_CHARS.len(); i++) begin
            n = NUMBER_CHARS[i];
            if (n == c) return 1'b1;
        end
        return 1'b0;
    endfunction

    function void bump_line();
        if (line_count != 16'hFFFF) line_count++;
    endfunction

    function logic [2:0] token_class_of();
        if (mode == LX_NUMBER) return ttl_pkg::CLS_NUMBER;
        if (mode == LX_STRING) return ttl_pkg::CLS_STRING;
        return ttl_pkg::CLS_SYMBOL;
    endfunction

    function void add_beat(logic [7:0] ch, bit has, logic [2:0] cls, bit first, bit last,
                           logic [15:0] line, logic [1:0] err);
        ttl_pkg::t_result r;
        r.char_value = ch;
        r.has_char = has;
        r.token_class = cls;
        r.first_of_token = first;
        r.last_of_token = last;
        r.line_number = line;
        r.error_code = err;
        r.last_result = 1'b0;
        expected_beats.push_back(r);
    endfunction

    // Emit the held character, if any, as the token's final beat; a cut string wins over overflow.
    function void close_token(logic [1:0] err);
        logic [1:0] code;
        code = err;
        if (code == ttl_pkg::ERR_NONE && overflow) code = ttl_pkg::ERR_TOO_LONG;
        if (held_valid)
            add_beat(held_char, 1'b1, token_class_of(), token_len == 1, 1'b1, token_line, code);
        else
            add_beat(8'd0, 1'b0, token_class_of(), 1'b1, 1'b1, token_line, code);
        mode = LX_IDLE;
        overflow = 1'b0;
        held_valid = 1'b0;
        held_char = 8'd0;
        token_len = 0;
    endfunction

    // A new character pushes out the held one; past the limit it is dropped.
    function void take_char(logic [7:0] c);
        if (token_len < MAX_TOKEN_CHARS) begin
            if (held_valid)
                add_beat(held_char, 1'b1, token_class_of(), token_len == 1, 1'b0, token_line,
                         ttl_pkg::ERR_NONE);
            held_char = c;
            held_valid = 1'b1;
            token_len++;
        end else begin
            overflow = 1'b1;
        end
    endfunction

    function void open_token(t_lex_mode m, logic [7:0] c);
        mode = m;
        overflow = 1'b0;
        token_line = line_count;
        if (m == LX_STRING) begin
            held_valid = 1'b0;
            held_char = 8'd0;
            token_len = 0;
        end else begin
            held_valid = 1'b1;
            held_char = c;
            token_len = 1;
        end
    endfunction

    // Start-of-token decision: whitespace, slash, number, string, delimiter, then symbol.
    function void between_tokens(logic [7:0] c);
        if (is_space(c)) begin
            if (c == ttl_pkg::CH_NEWLINE) bump_line();
        end else if (c == ttl_pkg::CH_SLASH) begin
            slash_wait = 1'b1;
            token_line = line_count;
        end else if ((c >= ttl_pkg::CH_DIGIT_0 && c <= ttl_pkg::CH_DIGIT_9) ||
                     c == ttl_pkg::CH_PLUS || c == ttl_pkg::CH_MINUS) begin
            open_token(LX_NUMBER, c);
        end else if (c == ttl_pkg::CH_QUOTE) begin
            open_token(LX_STRING, c);
        end else if (is_delim(c)) begin
            add_beat(c, 1'b1, ttl_pkg::CLS_DELIM, 1'b1, 1'b1, line_count, ttl_pkg::ERR_NONE);
        end else begin
            open_token(LX_SYMBOL, c);
        end
    endfunction

    function void symbol_char(logic [7:0] c);
        if (is_space(c) || is_delim(c)) begin
            close_token(ttl_pkg::ERR_NONE);
            between_tokens(c);
        end else begin
            take_char(c);
        end
    endfunction

    // Work out the result beats caused by one accepted byte.
    function void note_byte(logic [7:0] c, logic eot);
        int first_new;
        first_new = expected_beats.size();
        if (eot) begin
            if (slash_wait)
                add_beat(ttl_pkg::CH_SLASH, 1'b1,
                         is_delim(ttl_pkg::CH_SLASH) ? ttl_pkg::CLS_DELIM : ttl_pkg::CLS_SYMBOL,
                         1'b1, 1'b1, token_line, ttl_pkg::ERR_NONE);
            else if (mode == LX_NUMBER || mode == LX_SYMBOL)
                close_token(ttl_pkg::ERR_NONE);
            else if (mode == LX_STRING)
                close_token(ttl_pkg::ERR_EOT_IN_STR);
            add_beat(8'd0, 1'b0, ttl_pkg::CLS_END, 1'b1, 1'b1, line_count, ttl_pkg::ERR_NONE);
            clear_state();
        end else if (slash_wait) begin
            slash_wait = 1'b0;
            if (c == ttl_pkg::CH_SLASH) begin
                mode = LX_LINE_CMT;
            end else if (c == ttl_pkg::CH_STAR) begin
                mode = LX_BLOCK_CMT;
                star_seen = 1'b0;
            end else if (is_delim(ttl_pkg::CH_SLASH)) begin
                add_beat(ttl_pkg::CH_SLASH, 1'b1, ttl_pkg::CLS_DELIM, 1'b1, 1'b1, token_line,
                         ttl_pkg::ERR_NONE);
                between_tokens(c);
            end else begin
                mode = LX_SYMBOL;
                overflow = 1'b0;
                held_char = ttl_pkg::CH_SLASH;
                held_valid = 1'b1;
                token_len = 1;
                symbol_char(c);
            end
        end else begin
            case (mode)
                LX_LINE_CMT: begin
                    if (c == ttl_pkg::CH_NEWLINE) begin
                        bump_line();
                        mode = LX_IDLE;
                    end
                end
                LX_BLOCK_CMT: begin
                    if (c == ttl_pkg::CH_NEWLINE) bump_line();
                    if (star_seen && c == ttl_pkg::CH_SLASH) begin
                        mode = LX_IDLE;
                        star_seen = 1'b0;
                    end else begin
                        star_seen = (c == ttl_pkg::CH_STAR);
                    end
                end
                LX_NUMBER: begin
                    if (is_numeric(c)) begin
                        take_char(c);
                    end else begin
                        close_token(ttl_pkg::ERR_NONE);
                        between_tokens(c);
                    end
                end
                LX_STRING: begin
                    if (c == ttl_pkg::CH_QUOTE) begin
                        close_token(ttl_pkg::ERR_NONE);
                    end else if (c == ttl_pkg::CH_NEWLINE) begin
                        close_token(ttl_pkg::ERR_NL_IN_STR);
                        bump_line();
                    end else begin
                        take_char(c);
                    end
                end
                LX_SYMBOL: symbol_char(c);
                default: begin
                    mode = LX_IDLE;
                    between_tokens(c);
                end
            endcase
        end
        if (expected_beats.size() > first_new)
            expected_beats[expected_beats.size() - 1].last_result = 1'b1;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Compare one popped beat against the oldest expectation.
    function void check_beat(ttl_pkg::t_result got);
        ttl_pkg::t_result want;
        if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: char %0d class %0d",
                   got.char_value, got.token_class);
            errors++;
            return;
        end
        want = expected_beats.pop_front();
        beats_checked++;
        compare_field("char_value", 16'(want.char_value), 16'(got.char_value));
        compare_field("has_char", 16'(want.has_char), 16'(got.has_char));
        compare_field("token_class", 16'(want.token_class), 16'(got.token_class));
        compare_field("first_of_token", 16'(want.first_of_token), 16'(got.first_of_token));
        compare_field("last_of_token", 16'(want.last_of_token), 16'(got.last_of_token));
        compare_field("line_number", want.line_number, got.line_number);
        compare_field("error_code", 16'(want.error_code), 16'(got.error_code));
        compare_field("last_result", 16'(want.last_result), 16'(got.last_result));
    endfunction
endclass

module text_token_lexer_test;

    localparam int    CYCLE_LIMIT    = 1000000;
    localparam int    SETTLE_CYCLES  = 16;
    localparam int    LONG_HOLD      = 300;
    localparam int    MAX_TOKEN      = 255;
    localparam int    PHASE_BYTES    = 22;
    localparam string DELIM_CHARS    = ";,()[]{}=:";

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_index;
    logic [63:0] i_cfg_wr_data;
    logic        push;
    logic        full;
    logic [7:0]  i_text_byte;
    logic        i_end_of_text;
    logic        empty;
    logic        pop;
    logic [7:0]  o_char_value;
    logic        o_has_char;
    logic [2:0]  o_token_class;
    logic        o_first_of_token;
    logic        o_last_of_token;
    logic [15:0] o_line_number;
    logic [1:0]  o_error_code;
    logic        o_last_result;

    token_scoreboard token_board;
    int send_idle_pct;
    int recv_stall_pct;
    int stall_requests;
    int stall_served;
    int bytes_sent;
    int settings_used;
    int cycle_count;

    text_token_lexer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .push             (push),
        .full             (full),
        .i_text_byte      (i_text_byte),
        .i_end_of_text    (i_end_of_text),
        .empty            (empty),
        .pop              (pop),
        .o_char_value     (o_char_value),
        .o_has_char       (o_has_char),
        .o_token_class    (o_token_class),
        .o_first_of_token (o_first_of_token),
        .o_last_of_token  (o_last_of_token),
        .o_line_number    (o_line_number),
        .o_error_code     (o_error_code),
        .o_last_result    (o_last_result)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort the run if it takes far longer than any correct run could.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("run exceeded %0d cycles", CYCLE_LIMIT);
        $display("text_token_lexer test failed");
        $finish;
    end

    // Result side: check each popped beat, stall at random or for a long hold-off on request.
    initial begin
        int               hold_left;
        ttl_pkg::t_result got;
        hold_left = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got = '{o_char_value, o_has_char, o_token_class, o_first_of_token,
                        o_last_of_token, o_line_number, o_error_code, o_last_result};
                token_board.check_beat(got);
            end
            if (stall_served != stall_requests) begin
                stall_served = stall_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [127:0] delim_mask(input string chars);
        logic [127:0] m;
        logic [7:0]   ch;
        m = '0;
        for (int i = 0; i < chars.len(); i++) begin
            ch = chars[i];
            m[ch[6:0]] = 1'b1;
        end
        return m;
    endfunction

    // Offer one byte, with random idle cycles first, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_text_byte <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        token_board.note_byte(b, eot);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    // The data byte is ignored with the end mark, so it carries random bits.
    task automatic end_text();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Stop offering bytes until every expected beat is out and the pipeline is quiet.
    task automatic hold_until_drained();
        push <= 1'b0;
        while (token_board.beats_waiting() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both delimiter registers while the block is idle.
    task automatic set_delims(input logic [127:0] mask);
        hold_until_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= ttl_pkg::REG_DELIM_LOW;
        i_cfg_wr_data <= mask[63:0];
        @(posedge i_clk);
        i_cfg_index <= ttl_pkg::REG_DELIM_HIGH;
        i_cfg_wr_data <= mask[127:64];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        token_board.set_delims(mask);
        settings_used++;
    endtask

    function automatic logic [7:0] string_char();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return ttl_pkg::CH_NEWLINE;
        if (r == 1) return 8'($urandom_range(128, 255));
        return pick("ab 9/*;x#");
    endfunction

    // One mostly well-formed piece of text with random content, sometimes noise.
    task automatic send_fragment();
        int kind;
        int len;
        kind = $urandom_range(0, 19);
        len = $urandom_range(0, 5);
        case (kind)
            0, 1, 2, 3: begin
                send_byte(pick("+-0123456789"), 1'b0);
                repeat (len) send_byte(pick(NUMBER_CHARS), 1'b0);
            end
            4, 5, 6: begin
                send_byte(ttl_pkg::CH_QUOTE, 1'b0);
                repeat (len) send_byte(string_char(), 1'b0);
                if ($urandom_range(0, 7) != 0) send_byte(ttl_pkg::CH_QUOTE, 1'b0);
            end
            7, 8, 9: begin
                send_byte(pick("abcxyzQ_$@"), 1'b0);
                repeat (len) send_byte(8'($urandom_range(33, 126)), 1'b0);
            end
            10, 11: send_byte(pick(DELIM_CHARS), 1'b0);
            12: begin
                send_text("//");
                repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(ttl_pkg::CH_NEWLINE, 1'b0);
            end
            13: begin
                send_text("/*");
                repeat (len) send_byte(pick("*/\nab "), 1'b0);
                send_text("*/");
            end
            14: begin
                send_byte(ttl_pkg::CH_SLASH, 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            15, 16: send_byte(8'($urandom_range(0, 255)), 1'b0);
            17: end_text();
            default: send_byte(pick(" \t\n"), 1'b0);
        endcase
        if ($urandom_range(0, 9) < 7) send_byte(pick("  \n"), 1'b0);
    endtask

    task automatic random_text(input int n_items);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_items) send_fragment();
        end_text();
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct, input logic [127:0] mask);
        set_delims(mask);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        random_text(PHASE_BYTES);
    endtask

    // Main sequence.
    initial begin
        token_board = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stall_requests = 0;
        stall_served = 0;
        bytes_sent = 0;
        settings_used = 0;
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_text_byte <= 8'd0;
        i_end_of_text <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= ttl_pkg::REG_DELIM_LOW;
        i_cfg_wr_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every token class, quotes inside a symbol, empty string, block comment
        // across a line, slash starting a symbol and a slash left waiting at the end.
        set_delims(delim_mask(DELIM_CHARS));
        send_text("+7E# -x \"q\" a\"b;");
        end_text();
        send_text("\"\"/*\n**//z /");
        end_text();
        // Newline cuts a string, then the text ends inside another one.
        send_text("\"a\n\"b");
        end_text();
        // Line comment, whitespace extremes, a number ended by a waiting slash.
        send_text("//\n");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("1/");
        end_text();
        // Slash as a delimiter, a block comment that is not closed by its own opener,
        // and the text ending inside that comment.
        set_delims(delim_mask({DELIM_CHARS, "/"}));
        send_text("/;/*/x");
        end_text();

        // Random text under several delimiter sets and idling patterns.
        random_phase(0, 0, '0);
        random_phase(60, 0, delim_mask({DELIM_CHARS, "/"}));
        random_phase(0, 60, {128{1'b1}});
        random_phase(35, 35, {$urandom, $urandom, $urandom, $urandom});

        // Long receiver hold-off while short tokens keep coming, so the input side backs up.
        set_delims(delim_mask(DELIM_CHARS));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stall_requests++;
        repeat (10) begin
            send_byte(pick("abc"), 1'b0);
            send_byte(pick("xyz"), 1'b0);
            send_byte(pick(" ;"), 1'b0);
        end
        end_text();
        hold_until_drained();

        // A symbol one character past the length limit, closed by the end of text.
        send_idle_pct = 35;
        recv_stall_pct = 35;
        repeat (MAX_TOKEN + 1) send_byte("a", 1'b0);
        end_text();

        hold_until_drained();
        if (token_board.beats_waiting() != 0) begin
            $error("%0d expected result beats never arrived", token_board.beats_waiting());
            token_board.errors++;
        end
        $display("Sent %0d text bytes and checked %0d result beats under %0d delimiter settings.",
                 bytes_sent, token_board.beats_checked, settings_used);
        $display("Covered comments, cut strings, an over-long token and back-pressure.");
        if (token_board.errors == 0) begin
            $display("text_token_lexer test passed");
        end else begin
            $display("text_token_lexer test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/ttl_pkg.sv
design/ttl_front.sv
design/ttl_item_fifo.sv
design/ttl_back.sv
design/ttl_res_fifo.sv
design/text_token_lexer.sv
verif/text_token_lexer_test.sv
